>>> hw/rtl/ps2_host_line_interface_defines.svh
// Assertion macros used by the PS/2 host line interface RTL.
`ifndef PS2_HOST_LINE_INTERFACE_DEFINES_SVH
`define PS2_HOST_LINE_INTERFACE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PS2H_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ps2h assertion failed");

// Next-cycle implication, checked outside reset.
`define PS2H_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ps2h assertion failed");

`endif

>>> hw/rtl/ps2h_pkg.sv
// Types and constants of the PS/2 host line interface.
package ps2h_pkg;

  localparam int unsigned TickW = 16;
  localparam int unsigned TimeoutW = 20;
  localparam int unsigned ByteW = 8;
  localparam int unsigned BitCntW = 4;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 20;

  localparam logic [TickW-1:0] InhibitReset = 16'd100;
  localparam logic [TickW-1:0] SetupReset = 16'd10;
  localparam logic [TimeoutW-1:0] TimeoutReset = 20'd100000;
  localparam logic [BitCntW-1:0] BitsPerByte = 4'd8;

  typedef enum logic [CfgIdxW-1:0] {
    REG_INHIBIT = 2'd0,
    REG_SETUP   = 2'd1,
    REG_TIMEOUT = 2'd2
  } reg_idx_t;

  typedef enum logic [19:0] {
    PH_IDLE       = 20'h00001,
    PH_INHIBIT    = 20'h00002,
    PH_SETUP      = 20'h00004,
    PH_T_BIT_LO   = 20'h00008,
    PH_T_BIT_HI   = 20'h00010,
    PH_T_PAR_LO   = 20'h00020,
    PH_T_PAR_HI   = 20'h00040,
    PH_T_STP_LO   = 20'h00080,
    PH_T_STP_HI   = 20'h00100,
    PH_T_ACK_DLO  = 20'h00200,
    PH_T_ACK_CLO  = 20'h00400,
    PH_T_ACK_CHI  = 20'h00800,
    PH_T_ACK_DHI  = 20'h01000,
    PH_R_START_HI = 20'h02000,
    PH_R_BIT_LO   = 20'h04000,
    PH_R_BIT_HI   = 20'h08000,
    PH_R_PAR_LO   = 20'h10000,
    PH_R_PAR_HI   = 20'h20000,
    PH_R_STP_LO   = 20'h40000,
    PH_R_STP_HI   = 20'h80000
  } phase_t;

  typedef struct packed {
    logic             clk_drive_low;
    logic             data_drive_low;
    logic             rx_valid;
    logic [ByteW-1:0] rx_byte;
    logic             tx_done;
    logic             timed_out;
    logic             busy_res;
  } result_t;

endpackage

>>> hw/rtl/ps2h_item_if.sv
// Input channel of the PS/2 host line interface: one line sample or command per beat.
interface ps2h_item_if;
  logic                       valid;
  logic                       ready;
  logic                       cmd;
  logic [ps2h_pkg::ByteW-1:0] tx_byte;
  logic                       clk_in;
  logic                       data_in;

  modport source (output valid, cmd, tx_byte, clk_in, data_in, input ready);
  modport sink (input valid, cmd, tx_byte, clk_in, data_in, output ready);
endinterface

>>> hw/rtl/ps2h_result_if.sv
// Result channel of the PS/2 host line interface: line drives and status per beat.
interface ps2h_result_if;
  logic                       valid;
  logic                       ready;
  logic                       clk_drive_low;
  logic                       data_drive_low;
  logic                       rx_valid;
  logic [ps2h_pkg::ByteW-1:0] rx_byte;
  logic                       tx_done;
  logic                       timed_out;
  logic                       busy_res;

  modport source (output valid, clk_drive_low, data_drive_low, rx_valid, rx_byte,
                  tx_done, timed_out, busy_res, input ready);
  modport sink (input valid, clk_drive_low, data_drive_low, rx_valid, rx_byte,
                tx_done, timed_out, busy_res, output ready);
endinterface

>>> hw/rtl/ps2h_cfg_if.sv
// Configuration write channel of the PS/2 host line interface.
interface ps2h_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [ps2h_pkg::CfgIdxW-1:0]  index;
  logic [ps2h_pkg::CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> hw/rtl/ps2_host_line_interface.sv
// PS/2 host line engine: send and receive frames stepped once per sampled tick.
//
//   channel  | dir | payload
//   ---------+-----+-------------------------------------------------------------
//   item     | in  | cmd, tx_byte, clk_in, data_in
//   result   | out | clk_drive_low, data_drive_low, rx_valid, rx_byte, tx_done,
//            |     | timed_out, busy_res
//   cfg      | in  | index (0 inhibit, 1 setup, 2 timeout), data
//
// Every accepted item beat produces exactly one result beat, in the cycle after it is accepted.
// The frame state and the result register update in the same clock edge, so a new
// item can be taken every cycle while the result side takes its beats; the rate is one beat per cycle.
// A stalled result holds in the output register; item.ready drops only while that
// register is full and not being taken. Configuration writes are always accepted.
// Reset (rst, synchronous) returns the engine to idle with both lines released
// and the timing registers at 100, 10 and 100000 ticks.
`include "ps2_host_line_interface_defines.svh"

module ps2_host_line_interface (
  input  logic             clk,
  input  logic             rst,
  ps2h_item_if.sink        item,
  ps2h_result_if.source    result,
  ps2h_cfg_if.sink         cfg
);

  // Timing registers.
  logic [ps2h_pkg::TickW-1:0]    inhibit_ticks;
  logic [ps2h_pkg::TickW-1:0]    setup_ticks;
  logic [ps2h_pkg::TimeoutW-1:0] timeout_ticks;

  // Frame state and its next values.
  ps2h_pkg::phase_t               phase, phase_next;
  logic [ps2h_pkg::BitCntW-1:0]   bit_count, bit_count_next;
  logic [ps2h_pkg::ByteW-1:0]     shift_reg, shift_reg_next;
  logic                           parity_acc, parity_acc_next;
  logic [ps2h_pkg::TimeoutW-1:0]  tick_count, tick_count_next;
  logic                           data_low, data_low_next;
  logic                           clk_prev;

  // Output register.
  logic                           res_valid;
  ps2h_pkg::result_t              res, res_next;

  logic item_fire;
  logic falling;
  logic wait_met;
  logic rv, done, to;

  assign cfg.ready  = 1'b1;
  // The output register frees up when empty or when its beat is taken this cycle.
  assign item.ready = !res_valid || result.ready;
  assign item_fire  = item.valid && item.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      inhibit_ticks <= ps2h_pkg::InhibitReset;
      setup_ticks   <= ps2h_pkg::SetupReset;
      timeout_ticks <= ps2h_pkg::TimeoutReset;
    end else if (cfg.valid) begin
      case (cfg.index)
        ps2h_pkg::REG_INHIBIT: inhibit_ticks <= cfg.data[ps2h_pkg::TickW-1:0];
        ps2h_pkg::REG_SETUP:   setup_ticks   <= cfg.data[ps2h_pkg::TickW-1:0];
        ps2h_pkg::REG_TIMEOUT: timeout_ticks <= cfg.data;
        default: ;
      endcase
    end
  end

  // A falling edge is judged against the sample of the previous accepted beat.
  assign falling = clk_prev && !item.clk_in;

  // Each frame phase after setup waits on one line condition.
  always_comb begin
    case (phase)
      ps2h_pkg::PH_T_BIT_LO, ps2h_pkg::PH_T_PAR_LO, ps2h_pkg::PH_T_STP_LO,
      ps2h_pkg::PH_T_ACK_CLO, ps2h_pkg::PH_R_BIT_LO, ps2h_pkg::PH_R_PAR_LO,
      ps2h_pkg::PH_R_STP_LO:  wait_met = !item.clk_in;
      ps2h_pkg::PH_T_ACK_DLO: wait_met = !item.data_in;
      ps2h_pkg::PH_T_ACK_DHI: wait_met = item.data_in;
      default:                wait_met = item.clk_in;
    endcase
  end

  always_comb begin
    phase_next      = phase;
    bit_count_next  = bit_count;
    shift_reg_next  = shift_reg;
    parity_acc_next = parity_acc;
    tick_count_next = tick_count;
    data_low_next   = data_low;
    rv   = 1'b0;
    done = 1'b0;
    to   = 1'b0;

    if (phase == ps2h_pkg::PH_IDLE) begin
      // A command wins over a falling clock on the same tick.
      if (item.cmd) begin
        shift_reg_next  = item.tx_byte;
        parity_acc_next = 1'b1;
        bit_count_next  = '0;
        tick_count_next = ps2h_pkg::TimeoutW'(1);
        data_low_next   = 1'b0;
        phase_next      = ps2h_pkg::PH_INHIBIT;
      end else if (falling) begin
        shift_reg_next  = '0;
        bit_count_next  = '0;
        tick_count_next = '0;
        phase_next      = ps2h_pkg::PH_R_START_HI;
      end
    end else if (phase == ps2h_pkg::PH_INHIBIT) begin
      // A count of zero acts as one tick, since the count starts at one.
      if (tick_count >= ps2h_pkg::TimeoutW'(inhibit_ticks)) begin
        phase_next      = ps2h_pkg::PH_SETUP;
        tick_count_next = ps2h_pkg::TimeoutW'(1);
        data_low_next   = 1'b1;
      end else begin
        tick_count_next = tick_count + ps2h_pkg::TimeoutW'(1);
      end
    end else if (phase == ps2h_pkg::PH_SETUP) begin
      if (tick_count >= ps2h_pkg::TimeoutW'(setup_ticks)) begin
        phase_next      = ps2h_pkg::PH_T_BIT_LO;
        tick_count_next = '0;
      end else begin
        tick_count_next = tick_count + ps2h_pkg::TimeoutW'(1);
      end
    end else if (wait_met) begin
      tick_count_next = '0;
      case (phase)
        ps2h_pkg::PH_T_BIT_LO: begin
          // Present the next bit, LSB first; a one releases the data line.
          data_low_next   = !shift_reg[0];
          parity_acc_next = parity_acc ^ shift_reg[0];
          shift_reg_next  = {1'b0, shift_reg[ps2h_pkg::ByteW-1:1]};
          phase_next      = ps2h_pkg::PH_T_BIT_HI;
        end
        ps2h_pkg::PH_T_BIT_HI: begin
          bit_count_next = bit_count + ps2h_pkg::BitCntW'(1);
          phase_next     = (bit_count_next >= ps2h_pkg::BitsPerByte) ?
                           ps2h_pkg::PH_T_PAR_LO : ps2h_pkg::PH_T_BIT_LO;
        end
        ps2h_pkg::PH_T_PAR_LO: begin
          data_low_next = !parity_acc;
          phase_next    = ps2h_pkg::PH_T_PAR_HI;
        end
        ps2h_pkg::PH_T_PAR_HI: phase_next = ps2h_pkg::PH_T_STP_LO;
        ps2h_pkg::PH_T_STP_LO: begin
          data_low_next = 1'b0;
          phase_next    = ps2h_pkg::PH_T_STP_HI;
        end
        ps2h_pkg::PH_T_STP_HI: begin
          data_low_next = 1'b0;
          phase_next    = ps2h_pkg::PH_T_ACK_DLO;
        end
        ps2h_pkg::PH_T_ACK_DLO: phase_next = ps2h_pkg::PH_T_ACK_CLO;
        ps2h_pkg::PH_T_ACK_CLO: phase_next = ps2h_pkg::PH_T_ACK_CHI;
        ps2h_pkg::PH_T_ACK_CHI: phase_next = ps2h_pkg::PH_T_ACK_DHI;
        ps2h_pkg::PH_T_ACK_DHI: begin
          done           = 1'b1;
          bit_count_next = '0;
          phase_next     = ps2h_pkg::PH_IDLE;
        end
        ps2h_pkg::PH_R_START_HI: phase_next = ps2h_pkg::PH_R_BIT_LO;
        ps2h_pkg::PH_R_BIT_LO: begin
          shift_reg_next = {item.data_in, shift_reg[ps2h_pkg::ByteW-1:1]};
          phase_next     = ps2h_pkg::PH_R_BIT_HI;
        end
        ps2h_pkg::PH_R_BIT_HI: begin
          bit_count_next = bit_count + ps2h_pkg::BitCntW'(1);
          phase_next     = (bit_count_next >= ps2h_pkg::BitsPerByte) ?
                           ps2h_pkg::PH_R_PAR_LO : ps2h_pkg::PH_R_BIT_LO;
        end
        // Parity and stop bits are clocked through without a check.
        ps2h_pkg::PH_R_PAR_LO: phase_next = ps2h_pkg::PH_R_PAR_HI;
        ps2h_pkg::PH_R_PAR_HI: phase_next = ps2h_pkg::PH_R_STP_LO;
        ps2h_pkg::PH_R_STP_LO: phase_next = ps2h_pkg::PH_R_STP_HI;
        default: begin
          rv             = 1'b1;
          bit_count_next = '0;
          phase_next     = ps2h_pkg::PH_IDLE;
        end
      endcase
    end else if (tick_count >= timeout_ticks) begin
      // Give up: release both lines and go back to idle.
      to              = 1'b1;
      phase_next      = ps2h_pkg::PH_IDLE;
      data_low_next   = 1'b0;
      tick_count_next = '0;
      bit_count_next  = '0;
    end else begin
      tick_count_next = tick_count + ps2h_pkg::TimeoutW'(1);
    end
  end

  always_comb begin
    res_next.clk_drive_low  = (phase_next == ps2h_pkg::PH_INHIBIT) ||
                              (phase_next == ps2h_pkg::PH_SETUP);
    res_next.data_drive_low = (phase_next != ps2h_pkg::PH_IDLE) && data_low_next;
    res_next.rx_valid       = rv;
    res_next.rx_byte        = rv ? shift_reg : '0;
    res_next.tx_done        = done;
    res_next.timed_out      = to;
    res_next.busy_res       = (phase_next != ps2h_pkg::PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= ps2h_pkg::PH_IDLE;
      bit_count  <= '0;
      shift_reg  <= '0;
      parity_acc <= 1'b1;
      tick_count <= '0;
      data_low   <= 1'b0;
      clk_prev   <= 1'b1;
    end else if (item_fire) begin
      phase      <= phase_next;
      bit_count  <= bit_count_next;
      shift_reg  <= shift_reg_next;
      parity_acc <= parity_acc_next;
      tick_count <= tick_count_next;
      data_low   <= data_low_next;
      clk_prev   <= item.clk_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (item_fire) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_fire) begin
      res <= res_next;
    end
  end

  assign result.valid          = res_valid;
  assign result.clk_drive_low  = res.clk_drive_low;
  assign result.data_drive_low = res.data_drive_low;
  assign result.rx_valid       = res.rx_valid;
  assign result.rx_byte        = res.rx_byte;
  assign result.tx_done        = res.tx_done;
  assign result.timed_out      = res.timed_out;
  assign result.busy_res       = res.busy_res;

  // An empty output register must never hold back the item side.
  `PS2H_ASSERT_NOW(a_ready_when_empty, clk, rst, !res_valid, item.ready)
  // The bit counter never runs past one byte.
  `PS2H_ASSERT_NOW(a_bit_count_range, clk, rst, 1'b1, bit_count <= ps2h_pkg::BitsPerByte)
  // A frame end, completed or abandoned, leaves the engine idle and the lines free.
  `PS2H_ASSERT_NOW(a_end_is_idle, clk, rst,
                   result.valid && (result.tx_done || result.rx_valid || result.timed_out),
                   !result.busy_res && !result.clk_drive_low && !result.data_drive_low)
  // The host pulls the clock only during a send preamble, never while receiving.
  `PS2H_ASSERT_NOW(a_clk_drive_busy, clk, rst, result.valid && result.clk_drive_low,
                   result.busy_res && !result.rx_valid)
  // A timeout always lands in idle on the next edge after it is taken in.
  `PS2H_ASSERT_NEXT(a_timeout_idle, clk, rst, item_fire && to,
                    phase == ps2h_pkg::PH_IDLE)

endmodule
